// ----- rtl/svcd_pkg.sv -----
// ----------------------------------------------------------------------------
// svcd_pkg
// Shared types and constants for the servo width command decoder: command
// codes, register indexes, reset widths and the command record that passes
// from the byte parser to the width unit.
// ----------------------------------------------------------------------------
package svcd_pkg;

	// byte codes that open a command
	localparam logic [7:0] CMD_SET   = 8'd1;
	localparam logic [7:0] CMD_DELTA = 8'd170;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_NEUTRAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX     = 2'd2;

	// widths and reset values
	localparam int WIDTH_W = 16;
	localparam logic [WIDTH_W-1:0] NEUTRAL_RST = 16'd1500;
	localparam logic [WIDTH_W-1:0] MIN_RST     = 16'd1300;
	localparam logic [WIDTH_W-1:0] MAX_RST     = 16'd1700;
	localparam logic [WIDTH_W-1:0] PULSE_RST   = 16'd1500;

	// command queue between parser and width unit
	localparam int CQ_DEPTH = 2;
	localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
	localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

	// command kinds as reported on the result side
	localparam logic KIND_SET   = 1'b0;
	localparam logic KIND_DELTA = 1'b1;

	// one decoded command: set carries right/left, delta carries the delta in w0
	typedef struct packed {
		logic               kind;
		logic [WIDTH_W-1:0] w0;
		logic [WIDTH_W-1:0] w1;
	} cmd_t;

endpackage

// ----- rtl/svcd_front.sv -----
// ----------------------------------------------------------------------------
// svcd_front
// Byte parser: walks the command phases one received byte at a time,
// gathers the payload bytes and emits one command record per complete
// command.
// ----------------------------------------------------------------------------
module svcd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic [7:0]         rx_byte,
	input  logic               stall,
	output logic               full,
	output logic               cmd_valid,
	output svcd_pkg::cmd_t     cmd
);
	import svcd_pkg::*;

	typedef enum logic [6:0] {
		PH_IDLE   = 7'b0000001,
		PH_SET1   = 7'b0000010,
		PH_SET2   = 7'b0000100,
		PH_SET3   = 7'b0001000,
		PH_SET4   = 7'b0010000,
		PH_DELTA1 = 7'b0100000,
		PH_DELTA2 = 7'b1000000
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [23:0] part_q, part_d;
	logic        accept;

	assign full   = stall;
	assign accept = push && !stall;

	// next phase, payload gathering and command emission
	always_comb begin
		phase_d   = phase_q;
		part_d    = part_q;
		cmd_valid = 1'b0;
		cmd       = '0;
		if (accept) begin
			unique case (phase_q)
				PH_SET1: begin
					part_d[7:0] = rx_byte;
					phase_d     = PH_SET2;
				end
				PH_SET2: begin
					part_d[15:8] = rx_byte;
					phase_d      = PH_SET3;
				end
				PH_SET3: begin
					part_d[23:16] = rx_byte;
					phase_d       = PH_SET4;
				end
				PH_SET4: begin
					cmd_valid = 1'b1;
					cmd.kind  = KIND_SET;
					cmd.w0    = part_q[15:0];
					cmd.w1    = {rx_byte, part_q[23:16]};
					part_d    = '0;
					phase_d   = PH_IDLE;
				end
				PH_DELTA1: begin
					part_d  = {16'd0, rx_byte};
					phase_d = PH_DELTA2;
				end
				PH_DELTA2: begin
					cmd_valid = 1'b1;
					cmd.kind  = KIND_DELTA;
					cmd.w0    = {rx_byte, part_q[7:0]};
					part_d    = '0;
					phase_d   = PH_IDLE;
				end
				default: begin
					// idle: look for a command opener, drop anything else
					part_d = '0;
					if (rx_byte == CMD_SET) begin
						phase_d = PH_SET1;
					end else if (rx_byte == CMD_DELTA) begin
						phase_d = PH_DELTA1;
					end else begin
						phase_d = PH_IDLE;
					end
				end
			endcase
		end
	end

	// phase and payload registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			part_q  <= '0;
		end else begin
			phase_q <= phase_d;
			part_q  <= part_d;
		end
	end

endmodule

// ----- rtl/svcd_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// svcd_cmd_fifo
// Short command queue between the parser and the width unit, so that the
// parser keeps taking bytes while a result waits to be taken.
// ----------------------------------------------------------------------------
module svcd_cmd_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  svcd_pkg::cmd_t     wr_cmd,
	input  logic               rd_en,
	output svcd_pkg::cmd_t     rd_cmd,
	output logic               cq_full,
	output logic               cq_empty
);
	import svcd_pkg::*;

	cmd_t                mem_q [CQ_DEPTH];
	logic [CQ_PTR_W-1:0] wr_ptr_q;
	logic [CQ_PTR_W-1:0] rd_ptr_q;
	logic [CQ_CNT_W-1:0] cnt_q;
	logic                do_wr;
	logic                do_rd;

	assign cq_full  = (cnt_q == CQ_CNT_W'(CQ_DEPTH));
	assign cq_empty = (cnt_q == '0);
	assign do_wr    = wr_en && !cq_full;
	assign do_rd    = rd_en && !cq_empty;
	assign rd_cmd   = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/svcd_back.sv -----
// ----------------------------------------------------------------------------
// svcd_back
// Width unit: holds the limits and both pulse widths, carries out set and
// delta commands and keeps the result in an output register.
// ----------------------------------------------------------------------------
module svcd_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [svcd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [svcd_pkg::WIDTH_W-1:0]   cfg_data,
	input  logic                           cmd_avail,
	input  svcd_pkg::cmd_t                 cmd,
	output logic                           cmd_take,
	input  logic                           pop,
	output logic                           empty,
	output logic [svcd_pkg::WIDTH_W-1:0]   right_width,
	output logic [svcd_pkg::WIDTH_W-1:0]   left_width,
	output logic                           command_kind,
	output logic                           applied
);
	import svcd_pkg::*;

	logic [WIDTH_W-1:0] neutral_q, min_q, max_q;
	logic [WIDTH_W-1:0] right_q, left_q;
	logic [WIDTH_W-1:0] new_r, new_l;
	logic               ok;
	logic               out_valid_q;
	logic [WIDTH_W-1:0] right_out_q, left_out_q;
	logic               kind_out_q, applied_out_q;

	// width stays strictly on its side of neutral and inside the limits
	function automatic logic side_kept(
		input logic [WIDTH_W-1:0] old_w,
		input logic [WIDTH_W-1:0] new_w,
		input logic [WIDTH_W-1:0] neutral,
		input logic [WIDTH_W-1:0] lo,
		input logic [WIDTH_W-1:0] hi
	);
		logic above;
		logic below;
		above = (old_w > neutral) && (new_w > neutral);
		below = (old_w < neutral) && (new_w < neutral);
		return (above || below) && (new_w >= lo) && (new_w <= hi);
	endfunction

	// take a command when the output register is free or being emptied
	assign cmd_take = cmd_avail && (!out_valid_q || pop);

	// delta arithmetic, modulo 2^16
	assign new_r = right_q - cmd.w0;
	assign new_l = left_q + cmd.w0;
	assign ok    = side_kept(right_q, new_r, neutral_q, min_q, max_q) &&
	               side_kept(left_q, new_l, neutral_q, min_q, max_q);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neutral_q <= NEUTRAL_RST;
			min_q     <= MIN_RST;
			max_q     <= MAX_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NEUTRAL: neutral_q <= cfg_data;
				REG_MIN:     min_q     <= cfg_data;
				REG_MAX:     max_q     <= cfg_data;
				default:     ;
			endcase
		end
	end

	// pulse widths and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			right_q     <= PULSE_RST;
			left_q      <= PULSE_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd_take) begin
				out_valid_q <= 1'b1;
				if (cmd.kind == KIND_SET) begin
					right_q <= cmd.w0;
					left_q  <= cmd.w1;
				end else if (ok) begin
					right_q <= new_r;
					left_q  <= new_l;
				end
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd_take) begin
			kind_out_q <= cmd.kind;
			if (cmd.kind == KIND_SET) begin
				right_out_q   <= cmd.w0;
				left_out_q    <= cmd.w1;
				applied_out_q <= 1'b1;
			end else begin
				right_out_q   <= ok ? new_r : right_q;
				left_out_q    <= ok ? new_l : left_q;
				applied_out_q <= ok;
			end
		end
	end

	assign empty        = !out_valid_q;
	assign right_width  = right_out_q;
	assign left_width   = left_out_q;
	assign command_kind = kind_out_q;
	assign applied      = applied_out_q;

endmodule

// ----- rtl/servo_width_command_decoder_top.sv -----
// ----------------------------------------------------------------------------
// servo_width_command_decoder_top
// Serial command decoder that keeps the right and left motor pulse widths.
// ----------------------------------------------------------------------------
// Takes one received byte per clock while full is low and returns one result
// item per completed set or delta command. A command's result reaches the
// result ports through two registers: the byte parser writes the command into
// the two-entry command queue when it takes the last byte, and the width unit
// moves it into the output register once that register is free or popped.
// While results are popped, the width unit finishes one command per cycle and
// bytes are taken every cycle; when results are held back the queue fills and
// full rises until a result is taken. Limits are written through
// cfg_we/cfg_index/cfg_data and should be changed only while no command is
// in flight.
module servo_width_command_decoder_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [svcd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [svcd_pkg::WIDTH_W-1:0]   cfg_data,
	input  logic                           push,
	output logic                           full,
	input  logic [7:0]                     rx_byte,
	output logic                           empty,
	input  logic                           pop,
	output logic [svcd_pkg::WIDTH_W-1:0]   right_width,
	output logic [svcd_pkg::WIDTH_W-1:0]   left_width,
	output logic                           command_kind,
	output logic                           applied
);
	import svcd_pkg::*;

	logic cmd_valid;
	cmd_t cmd_in;
	cmd_t cmd_out;
	logic cq_full;
	logic cq_empty;
	logic cq_pop;

	// byte parser
	svcd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.rx_byte   (rx_byte),
		.stall     (cq_full),
		.full      (full),
		.cmd_valid (cmd_valid),
		.cmd       (cmd_in)
	);

	// command queue
	svcd_cmd_fifo u_cq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cmd_valid),
		.wr_cmd   (cmd_in),
		.rd_en    (cq_pop),
		.rd_cmd   (cmd_out),
		.cq_full  (cq_full),
		.cq_empty (cq_empty)
	);

	// width unit
	svcd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd_avail    (!cq_empty),
		.cmd          (cmd_out),
		.cmd_take     (cq_pop),
		.pop          (pop),
		.empty        (empty),
		.right_width  (right_width),
		.left_width   (left_width),
		.command_kind (command_kind),
		.applied      (applied)
	);

`ifndef ASSERT_OFF
	// a set command always applies its widths
	a_set_applied: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && command_kind == KIND_SET) |-> applied)
		else $error("set command result not marked applied");

	// queue never reports full and empty together
	a_cq_flags: assert property (@(posedge clk) disable iff (!arst_n)
		!(cq_full && cq_empty))
		else $error("command queue full and empty at once");

	// a popped result with nothing behind it leaves the output empty
	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !cq_pop) |=> empty)
		else $error("result still shown after pop with no new command");

	// the width unit never takes a command it has no room for
	a_take_room: assert property (@(posedge clk) disable iff (!arst_n)
		cq_pop |-> (!cq_empty && (empty || pop)))
		else $error("command taken without room in the output register");
`endif

endmodule
